/* rtl/sst_pkg.sv */
// Shared definitions for the sorted set table: operation codes, status codes
// and the command that the top level broadcasts to every storage cell.
// No dependencies.
package sst_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_MISS = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   // Broadcast to all cells in the cycle a request is accepted.
   typedef struct packed {
      logic ins;    // shift right from the insert point and place the key
      logic del;    // shift left over the matching entry
   } cell_cmd_type;

endpackage

/* rtl/sst_cell.sv */
// One storage cell of the sorted set table: holds a single key, compares it
// against the request key and takes the request key or a neighbor's key on an insert or remove.
// Depends on sst_pkg.
module sst_cell #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                  clock,
   input  sst_pkg::cell_cmd_type cmd,
   input  logic [KEY_WIDTH-1:0]  req_key,
   input  logic                  cell_valid,
   input  logic                  left_lt,
   input  logic [KEY_WIDTH-1:0]  left_key,
   input  logic [KEY_WIDTH-1:0]  right_key,
   output logic [KEY_WIDTH-1:0]  key,
   output logic                  lt,
   output logic                  eq
);
   import sst_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   assign key = key_ff;
   assign lt  = cell_valid && (key_ff < req_key);
   assign eq  = cell_valid && (key_ff == req_key);

   // Cells holding smaller keys never move. The first cell at or above the
   // request key takes the new key on an insert, later cells shift right; on a remove all such cells shift left.
   always_comb begin
      key_in = key_ff;
      if (!lt) begin
         if (cmd.ins) begin
            key_in = left_lt ? req_key : left_key;
         end else if (cmd.del) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

/* rtl/sorted_set_table_core.sv */
// Sorted set table: a bounded set of unique keys kept in ascending unsigned
// order in a row of storage cells. Depends on sst_pkg and sst_cell.
//
// Usage: one request (insert, remove, lookup or clear) is accepted per clock
// cycle while req_stall is low, and its response appears on the rsp_ ports
// on the following cycle. Every cell compares its key against the request
// key in the same cycle and shifts left or right by one place, so the whole
// operation completes in the cycle it is accepted; the clock rate is set by
// the depth of the compare and the CAPACITY-wide hit detection across the
// cells. The response register holds a result while rsp_stall is high, and
// req_stall is raised only while a response waits. An insert of a new key
// into a full table is refused with the full status. Reset empties the table.
module sorted_set_table_core #(
   parameter int  CAPACITY  = 64,
   parameter int  KEY_WIDTH = 32,
   localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [KEY_WIDTH-1:0] req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ok,
   output logic [1:0]           rsp_status,
   output logic [KEY_WIDTH-1:0] rsp_found_key,
   output logic [CNT_W-1:0]     rsp_entry_count,
   output logic                 rsp_is_empty
);
   import sst_pkg::*;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_ok_ff;
   logic                 rsp_ok_in;
   status_type           rsp_status_ff;
   status_type           rsp_status_in;
   logic [KEY_WIDTH-1:0] rsp_found_key_ff;
   logic [KEY_WIDTH-1:0] rsp_found_key_in;
   logic [CNT_W-1:0]     rsp_entry_count_ff;
   logic                 rsp_is_empty_ff;

   logic                 accept;
   logic                 hit;
   logic                 full;
   cell_cmd_type         cmd;

   logic [CAPACITY-1:0]  cell_valid;
   logic [CAPACITY-1:0]  cell_lt;
   logic [CAPACITY-1:0]  cell_eq;
   logic [KEY_WIDTH-1:0] cell_key [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign hit  = |cell_eq;
   assign full = (count_ff == CNT_W'(CAPACITY));

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                 left_lt;
         logic [KEY_WIDTH-1:0] left_key;
         logic [KEY_WIDTH-1:0] right_key;

         assign cell_valid[gi] = (count_ff > CNT_W'(gi));

         if (gi == 0) begin : g_first
            // The head of the row sees an imaginary smaller neighbor.
            assign left_lt  = 1'b1;
            assign left_key = req_key;
         end else begin : g_inner
            assign left_lt  = cell_lt[gi-1];
            assign left_key = cell_key[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[gi];
         end else begin : g_body
            assign right_key = cell_key[gi+1];
         end

         sst_cell #(
            .KEY_WIDTH (KEY_WIDTH)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .req_key    (req_key),
            .cell_valid (cell_valid[gi]),
            .left_lt    (left_lt),
            .left_key   (left_key),
            .right_key  (right_key),
            .key        (cell_key[gi]),
            .lt         (cell_lt[gi]),
            .eq         (cell_eq[gi])
         );
      end
   endgenerate

   always_comb begin
      cmd              = '0;
      count_in         = count_ff;
      rsp_ok_in        = 1'b0;
      rsp_status_in    = ST_OK;
      rsp_found_key_in = '0;
      case (op_type'(req_opcode))
         OP_INSERT: begin
            if (hit) begin
               rsp_status_in = ST_DUP;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.ins   = accept;
               count_in  = count_ff + CNT_W'(1);
               rsp_ok_in = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               cmd.del          = accept;
               count_in         = count_ff - CNT_W'(1);
               rsp_ok_in        = 1'b1;
               rsp_found_key_in = req_key;
            end else begin
               rsp_status_in = ST_MISS;
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               rsp_ok_in        = 1'b1;
               rsp_found_key_in = req_key;
            end else begin
               rsp_status_in = ST_MISS;
            end
         end
         OP_CLEAR: begin
            count_in  = '0;
            rsp_ok_in = 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff          <= rsp_ok_in;
         rsp_status_ff      <= rsp_status_in;
         rsp_found_key_ff   <= rsp_found_key_in;
         rsp_entry_count_ff <= count_in;
         rsp_is_empty_ff    <= (count_in == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_key   = rsp_found_key_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

endmodule
